### rtl/core/pfa_pkg.sv
// ============================================================================
// pfa_pkg: shared definitions for the paging frame allocator
// Field widths, command and status codes, and parameter defaults.
// ============================================================================
package pfa_pkg;

    // Field widths of the input and result words
    localparam int CMD_W  = 2;
    localparam int PID_W  = 6;
    localparam int PGI_W  = 6;
    localparam int REQ_W  = 7;
    localparam int PCNT_W = 7;
    localparam int ST_W   = 3;
    localparam int FREE_W = 7;
    localparam int CFG_W  = 7;

    // Parameter defaults
    localparam int FRAMES_DEF = 64;
    localparam int PROCS_DEF  = 64;
    localparam int PAGES_DEF  = 64;

    // Frame count register value after reset
    localparam logic [CFG_W-1:0] CFG_FRAMES_RST = 7'd64;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [ST_W-1:0]  t_status;

    // Commands
    localparam t_cmd CMD_DECLARE = 2'd0;
    localparam t_cmd CMD_MAP     = 2'd1;
    localparam t_cmd CMD_TERM    = 2'd2;

    // Result status codes
    localparam t_status ST_MAPPED       = 3'd0;
    localparam t_status ST_TOO_LARGE    = 3'd1;
    localparam t_status ST_OUT_OF_RANGE = 3'd2;
    localparam t_status ST_OCCUPIED     = 3'd3;
    localparam t_status ST_FREED        = 3'd4;
    localparam t_status ST_DECLARED     = 3'd5;

endpackage

### rtl/core/pfa_ram.sv
// ============================================================================
// pfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write then register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/paging_frame_allocator.sv
// ============================================================================
// paging_frame_allocator: physical frame allocator with per-process page table
// Keeps a used bit per frame, a page count per process and a page table in
// RAM. Declare, map and terminate commands each return one result word.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  input   | in        | i_valid / o_stall   | command, process_id, page_index,
//          |           |                     | frame_request, page_count
//  result  | out       | o_valid / i_stall   | status, free_frames,
//          |           |                     | short_of_frames
//  config  | in        | i_cfg_wr_en         | i_cfg_wr_data (frame count)
//
//  Terminate, and a map that finds the process too large, walk the page table
//  over the single RAM port. Index reduction subtracts PROCS or PAGES while an
//  id or index is out of range. Reset: a clearing pass writes every page-table
//  and page-count entry, one per cycle, then a recount of the free frames
//  follows; o_stall stays high meanwhile. A frame count write outside the
//  clearing pass starts the same recount, with o_stall high.
//  A finished result waits in the output register; a new word is accepted
//  while it is stalled, and that word's result waits for the register.
//
module paging_frame_allocator
    import pfa_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    parameter int PROCS  = PROCS_DEF,
    parameter int PAGES  = PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [PID_W-1:0]  i_process_id,
    input  logic [PGI_W-1:0]  i_page_index,
    input  logic [REQ_W-1:0]  i_frame_request,
    input  logic [PCNT_W-1:0] i_page_count,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [FREE_W-1:0] o_free_frames,
    output logic              o_short_of_frames,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data
);

    // Only frames below 128 can ever be addressed by a request
    localparam int NF       = (FRAMES < 128) ? FRAMES : 128;
    localparam int FW       = $clog2(NF);
    localparam int PW       = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int GW       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW       = PW + GW;
    localparam int PT_DEPTH = 1 << AW;
    localparam int PC_DEPTH = 1 << PW;
    localparam int CNTW     = $clog2(PAGES + 1);
    localparam int EW       = FW + 1;
    localparam int IW       = (AW > FW) ? AW : FW;
    localparam logic [FREE_W-1:0] NOF_RST =
        (int'(CFG_FRAMES_RST) < FRAMES) ? CFG_FRAMES_RST : FREE_W'(FRAMES);

    // Sequencer states
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_RECOUNT = 3'd1;
    localparam logic [2:0] S_IDLE    = 3'd2;
    localparam logic [2:0] S_REDUCE  = 3'd3;
    localparam logic [2:0] S_NEED    = 3'd4;
    localparam logic [2:0] S_PTCHK   = 3'd5;
    localparam logic [2:0] S_WALK    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]        r_state,  n_state;
    logic [IW-1:0]     r_idx,    n_idx;
    logic              r_rd_on,  n_rd_on;
    logic              r_rdv,    n_rdv;
    logic [GW-1:0]     r_widx,   n_widx;
    logic [CMD_W-1:0]  r_cmd,    n_cmd;
    logic [PID_W-1:0]  r_pid,    n_pid;
    logic [PGI_W-1:0]  r_pg,     n_pg;
    logic [REQ_W-1:0]  r_req,    n_req;
    logic [PCNT_W-1:0] r_pcnt,   n_pcnt;
    logic [FREE_W-1:0] r_nof,    n_nof;
    logic [FREE_W-1:0] r_cnt,    n_cnt;
    logic [NF-1:0]     r_used,   n_used;
    logic [ST_W-1:0]   r_status, n_status;
    logic              r_short,  n_short;
    logic              r_ovalid, n_ovalid;
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [FREE_W-1:0] r_o_free,   n_o_free;
    logic              r_o_short,  n_o_short;

    logic [PW-1:0]     w_pid;
    logic [GW-1:0]     w_pg;
    logic [AW-1:0]     w_pt_rd_addr, w_pt_wr_addr;
    logic [EW-1:0]     w_pt_rd_data, w_pt_wr_data;
    logic              w_pt_wr_en;
    logic [PW-1:0]     w_pc_wr_addr;
    logic [CNTW-1:0]   w_pc_rd_data, w_pc_wr_data;
    logic              w_pc_wr_en;
    logic [FW-1:0]     w_fidx;
    logic              w_used_bit;
    logic              w_fidx_in;
    logic [CNTW-1:0]   w_sat;
    logic [FREE_W-1:0] w_cfg_eff;
    logic              w_red_pid, w_red_pg;
    logic [8:0]        w_red_a, w_red_k, w_red_d;
    logic              w_ent_valid;
    logic              w_inc;

    assign w_pid = PW'(r_pid);
    assign w_pg  = GW'(r_pg);

    // Page table: one entry per process page, valid bit over frame number
    pfa_ram #(.WIDTH(EW), .DEPTH(PT_DEPTH)) u_pt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_pt_wr_en),
        .i_wr_addr (w_pt_wr_addr),
        .i_wr_data (w_pt_wr_data),
        .i_rd_addr (w_pt_rd_addr),
        .o_rd_data (w_pt_rd_data)
    );

    // Declared page count per process
    pfa_ram #(.WIDTH(CNTW), .DEPTH(PC_DEPTH)) u_pc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_pc_wr_en),
        .i_wr_addr (w_pc_wr_addr),
        .i_wr_data (w_pc_wr_data),
        .i_rd_addr (w_pid),
        .o_rd_data (w_pc_rd_data)
    );

    // Walk reads by the sweep index, everything else by the requested page
    assign w_pt_rd_addr = (r_state == S_WALK) ? {w_pid, r_idx[GW-1:0]} : {w_pid, w_pg};
    assign w_ent_valid  = w_pt_rd_data[FW];

    // Page-table write port
    always_comb begin
        w_pt_wr_en   = 1'b0;
        w_pt_wr_addr = {w_pid, w_pg};
        w_pt_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                w_pt_wr_en   = 1'b1;
                w_pt_wr_addr = r_idx[AW-1:0];
            end
            S_PTCHK: begin
                w_pt_wr_en   = 1'b1;
                w_pt_wr_data = {1'b1, FW'(r_req)};
            end
            S_WALK: begin
                w_pt_wr_en   = r_rdv;
                w_pt_wr_addr = {w_pid, r_widx};
            end
            default: begin
                w_pt_wr_en = 1'b0;
            end
        endcase
    end

    // Saturate a declared count at PAGES, the number of pages per process
    assign w_sat = (9'(r_pcnt) < 9'(PAGES)) ? CNTW'(r_pcnt) : CNTW'(PAGES);

    // Page-count write port: clear pass or declare
    assign w_pc_wr_addr = (r_state == S_CLEAR) ? r_idx[AW-1:GW] : w_pid;
    assign w_pc_wr_data = (r_state == S_CLEAR) ? '0 : w_sat;
    assign w_pc_wr_en   = (r_state == S_CLEAR) ||
                          ((r_state == S_REDUCE) && !w_red_pid && !w_red_pg &&
                           (r_cmd == CMD_DECLARE));

    // Single read port on the frame used bits
    always_comb begin
        case (r_state)
            S_RECOUNT:      w_fidx = r_idx[FW-1:0];
            S_NEED:         w_fidx = FW'(r_req);
            S_PTCHK,
            S_WALK:         w_fidx = w_pt_rd_data[FW-1:0];
            default:        w_fidx = '0;
        endcase
    end
    assign w_used_bit = r_used[w_fidx];
    assign w_fidx_in  = 8'(w_fidx) < 8'(r_nof);

    // Shared reduce unit: subtract PROCS or PAGES from an out-of-range index
    assign w_red_pid = 9'(r_pid) >= 9'(PROCS);
    assign w_red_pg  = 9'(r_pg) >= 9'(PAGES);
    assign w_red_a   = w_red_pid ? 9'(r_pid) : 9'(r_pg);
    assign w_red_k   = w_red_pid ? 9'(PROCS) : 9'(PAGES);
    assign w_red_d   = w_red_a - w_red_k;

    assign w_cfg_eff = (11'(i_cfg_wr_data) < 11'(FRAMES)) ? i_cfg_wr_data : FREE_W'(FRAMES);

    // A freed frame counts when it was in use below the frame count
    assign w_inc = w_ent_valid && w_used_bit && w_fidx_in;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_on    = r_rd_on;
        n_rdv      = r_rdv;
        n_widx     = r_widx;
        n_cmd      = r_cmd;
        n_pid      = r_pid;
        n_pg       = r_pg;
        n_req      = r_req;
        n_pcnt     = r_pcnt;
        n_nof      = r_nof;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_status   = r_status;
        n_short    = r_short;
        n_ovalid   = r_ovalid && i_stall;
        n_o_status = r_o_status;
        n_o_free   = r_o_free;
        n_o_short  = r_o_short;

        case (r_state)
            // Sweep both RAMs to their reset contents
            S_CLEAR: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(PT_DEPTH - 1)) begin
                    n_state = S_RECOUNT;
                    n_idx   = '0;
                    n_cnt   = '0;
                end
            end
            // Count free frames below the frame count
            S_RECOUNT: begin
                n_cnt = r_cnt + FREE_W'(w_fidx_in && !w_used_bit);
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(NF - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // Take a word
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_pid   = i_process_id;
                    n_pg    = i_page_index;
                    n_req   = i_frame_request;
                    n_pcnt  = i_page_count;
                    n_short = 1'b0;
                    n_state = S_REDUCE;
                end
            end
            // Fold indexes into range, then dispatch on the command
            S_REDUCE: begin
                if (w_red_pid) begin
                    n_pid = PID_W'(w_red_d);
                end else if (w_red_pg) begin
                    n_pg = PGI_W'(w_red_d);
                end else begin
                    case (r_cmd)
                        CMD_MAP: begin
                            n_state = S_NEED;
                        end
                        CMD_TERM: begin
                            n_status = ST_FREED;
                            n_idx    = '0;
                            n_rd_on  = 1'b1;
                            n_rdv    = 1'b0;
                            n_state  = S_WALK;
                        end
                        default: begin
                            n_status = ST_DECLARED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            // Check process size, range and occupancy
            S_NEED: begin
                if (9'(w_pc_rd_data) > 9'(r_nof)) begin
                    n_status = ST_TOO_LARGE;
                    n_idx    = '0;
                    n_rd_on  = 1'b1;
                    n_rdv    = 1'b0;
                    n_state  = S_WALK;
                end else if ((r_req >= r_nof) || w_used_bit) begin
                    n_status = (r_req >= r_nof) ? ST_OUT_OF_RANGE : ST_OCCUPIED;
                    n_short  = (r_cnt == '0) || (9'(r_cnt) < 9'(w_pc_rd_data));
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PTCHK;
                end
            end
            // Release the old frame of the page and take the new one
            S_PTCHK: begin
                if (w_ent_valid) begin
                    n_used[w_fidx] = 1'b0;
                end
                n_used[FW'(r_req)] = 1'b1;
                n_cnt    = r_cnt + FREE_W'(w_inc) - FREE_W'(1);
                n_status = ST_MAPPED;
                n_state  = S_DONE;
            end
            // Walk the process pages: read one entry, free the previous one
            S_WALK: begin
                if (r_rd_on) begin
                    n_idx = r_idx + IW'(1);
                    if (r_idx == IW'(PAGES - 1)) begin
                        n_rd_on = 1'b0;
                    end
                end
                n_rdv  = r_rd_on;
                n_widx = r_idx[GW-1:0];
                if (r_rdv) begin
                    if (w_ent_valid) begin
                        n_used[w_fidx] = 1'b0;
                    end
                    n_cnt = r_cnt + FREE_W'(w_inc);
                end
                if (!r_rd_on && r_rdv) begin
                    n_state = S_DONE;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_free   = r_cnt;
                    n_o_short  = r_short;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Frame count write: store, and recount outside the clearing pass
        if (i_cfg_wr_en) begin
            n_nof = w_cfg_eff;
            if (r_state != S_CLEAR) begin
                n_state = S_RECOUNT;
                n_idx   = '0;
                n_cnt   = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_rd_on  <= 1'b0;
            r_rdv    <= 1'b0;
            r_nof    <= NOF_RST;
            r_cnt    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_on  <= n_rd_on;
            r_rdv    <= n_rdv;
            r_nof    <= n_nof;
            r_cnt    <= n_cnt;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_cmd      <= n_cmd;
        r_pid      <= n_pid;
        r_pg       <= n_pg;
        r_req      <= n_req;
        r_pcnt     <= n_pcnt;
        r_status   <= n_status;
        r_short    <= n_short;
        r_o_status <= n_o_status;
        r_o_free   <= n_o_free;
        r_o_short  <= n_o_short;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_status          = r_o_status;
    assign o_free_frames     = r_o_free;
    assign o_short_of_frames = r_o_short;

endmodule

### rtl/core/pfa_checker.sv
// ============================================================================
// pfa_checker: port-level checks for the paging frame allocator
// Watches the top-level ports and is attached by a bind statement.
// ============================================================================
module pfa_checker
    import pfa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [CMD_W-1:0]  i_command,
    input logic [PID_W-1:0]  i_process_id,
    input logic [PGI_W-1:0]  i_page_index,
    input logic [REQ_W-1:0]  i_frame_request,
    input logic [PCNT_W-1:0] i_page_count,
    input logic              o_valid,
    input logic              i_stall,
    input logic [ST_W-1:0]   o_status,
    input logic [FREE_W-1:0] o_free_frames,
    input logic              o_short_of_frames,
    input logic              i_cfg_wr_en,
    input logic [CFG_W-1:0]  i_cfg_wr_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_status) && $stable(o_free_frames) &&
                                  $stable(o_short_of_frames)))
        else $error("stalled result word changed");

    // Go busy after taking a word
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second word taken while the first is in work");

    // Short-of-frames only comes with a failed map
    a_short_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_short_of_frames) |->
            ((o_status == ST_OUT_OF_RANGE) || (o_status == ST_OCCUPIED)))
        else $error("short-of-frames flag on a status that cannot carry it");

    // A free count of 127 is impossible after a map success
    a_mapped_not_all_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_MAPPED)) |-> (o_free_frames != 7'd127))
        else $error("free count too large after a mapped word");

endmodule

bind paging_frame_allocator pfa_checker u_pfa_checker (.*);
